// ===== rtl/tcf_pkg.sv =====
package tcf_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int ID_W        = 16;
   localparam int STAMP_W     = 32;

   typedef enum logic {
      CMD_ADMIT = 1'b0,
      CMD_TAKE  = 1'b1
   } command_type;

   typedef enum logic [1:0] {
      CH_ANY = 2'd0,
      CH_A   = 2'd1,
      CH_B   = 2'd2
   } choice_type;

   typedef enum logic [1:0] {
      ST_TAKEN    = 2'd0,
      ST_ADMITTED = 2'd1,
      ST_IGNORED  = 2'd2,
      ST_DROPPED  = 2'd3
   } status_type;

   // per-queue operation for one cycle
   typedef struct packed {
      logic                       push;
      logic                       pop;
      logic signed [ID_W-1:0]     id;
      logic        [STAMP_W-1:0]  stamp;
   } q_ctrl_type;

   // per-queue status, front entry valid when not empty
   typedef struct packed {
      logic                       empty;
      logic                       full;
      logic signed [ID_W-1:0]     id;
      logic        [STAMP_W-1:0]  stamp;
   } q_stat_type;

   // wrap-aware age compare: a is older when (a - b) has its top bit set
   function automatic logic stamp_older(input logic [STAMP_W-1:0] a,
                                        input logic [STAMP_W-1:0] b);
      logic [STAMP_W-1:0] diff;
      diff = a - b;
      return diff[STAMP_W-1];
   endfunction

endpackage

// ===== rtl/tcf_req_if.sv =====
interface tcf_req_if;
   logic                             valid;
   logic                             ready;
   logic                             command;
   logic signed [tcf_pkg::ID_W-1:0]  item_id;
   logic [1:0]                       choice;

   modport source (output valid, output command, output item_id, output choice,
                   input ready);
   modport sink   (input valid, input command, input item_id, input choice,
                   output ready);
endinterface

// ===== rtl/tcf_rsp_if.sv =====
interface tcf_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [1:0]                       status;
   logic signed [tcf_pkg::ID_W-1:0]  taken_id;

   modport source (output valid, output status, output taken_id, input ready);
   modport sink   (input valid, input status, input taken_id, output ready);
endinterface

// ===== rtl/tcf_ram.sv =====
module tcf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/tcf_queue.sv =====
module tcf_queue #(
   parameter int DEPTH = tcf_pkg::QUEUE_DEPTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  tcf_pkg::q_ctrl_type  ctrl,
   output tcf_pkg::q_stat_type  stat
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int ENT_W = tcf_pkg::ID_W + tcf_pkg::STAMP_W;

   logic [PTR_W-1:0] head_ff, head_in;
   logic [PTR_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             byp_sel_ff, byp_sel_in;
   logic [ENT_W-1:0] byp_data_ff;
   logic [ENT_W-1:0] wr_data;
   logic [ENT_W-1:0] rd_data;
   logic [ENT_W-1:0] front;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign wr_data = {ctrl.id, ctrl.stamp};

   always_comb begin
      head_in  = ctrl.pop  ? ptr_next(head_ff) : head_ff;
      tail_in  = ctrl.push ? ptr_next(tail_ff) : tail_ff;
      count_in = count_ff;
      if (ctrl.push && !ctrl.pop) begin
         count_in = count_ff + 1'b1;
      end else if (ctrl.pop && !ctrl.push) begin
         count_in = count_ff - 1'b1;
      end
      // RAM read is registered: the word written to the slot about to become
      // the front is held aside in a bypass register
      byp_sel_in = ctrl.push && (tail_ff == head_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff    <= '0;
         tail_ff    <= '0;
         count_ff   <= '0;
         byp_sel_ff <= 1'b0;
      end else begin
         head_ff    <= head_in;
         tail_ff    <= tail_in;
         count_ff   <= count_in;
         byp_sel_ff <= byp_sel_in;
      end
   end

   always_ff @(posedge clock) begin
      byp_data_ff <= wr_data;
   end

   tcf_ram #(
      .WIDTH (ENT_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (ctrl.push),
      .waddr (tail_ff),
      .wdata (wr_data),
      .raddr (head_in),
      .rdata (rd_data)
   );

   assign front = byp_sel_ff ? byp_data_ff : rd_data;

   always_comb begin
      stat.empty = (count_ff == '0);
      stat.full  = (count_ff == CNT_W'(DEPTH));
      stat.id    = front[ENT_W-1 -: tcf_pkg::ID_W];
      stat.stamp = front[tcf_pkg::STAMP_W-1:0];
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue count beyond depth");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      ctrl.pop |-> count_ff != '0)
      else $error("pop from empty queue");

   a_push_count: assert property (@(posedge clock) disable iff (reset)
      (ctrl.push && !ctrl.pop) |=> count_ff == CNT_W'($past(count_ff) + 1'b1))
      else $error("push did not bump count");

   a_ptr_match: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0 || count_ff == CNT_W'(DEPTH)) |-> head_ff == tail_ff)
      else $error("pointers disagree with count");

endmodule

// ===== rtl/two_class_fifo_oldest_first.sv =====
// channel | dir | handshake           | word
// --------+-----+---------------------+---------------------------------
// req_ch  | in  | valid/ready         | command, item_id, choice
// rsp_ch  | out | valid/ready         | status, taken_id
//
// One word accepted per cycle unless the result side stalls; its word passes
// the input register, then the result register, before its result is valid.
// Per-class FIFOs sit in RAMs with registered read; the front entry is read
// ahead from the next head pointer, so back-to-back takes run without gaps.
// Synchronous reset empties both classes and zeroes the arrival stamp.
// A stalled result holds the input register; req_ch.ready drops only then.
module two_class_fifo_oldest_first #(
   parameter int QUEUE_DEPTH = tcf_pkg::QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   tcf_req_if.sink     req_ch,
   tcf_rsp_if.source   rsp_ch
);

   logic                                 in_valid_ff, in_valid_in;
   logic                                 cmd_ff;
   logic signed [tcf_pkg::ID_W-1:0]      id_ff;
   logic [1:0]                           choice_ff;
   logic [tcf_pkg::STAMP_W-1:0]          arrival_ff, arrival_in;
   logic                                 rsp_valid_ff, rsp_valid_in;
   logic [1:0]                           status_ff;
   logic signed [tcf_pkg::ID_W-1:0]      taken_ff;

   logic                                 req_take;
   logic                                 out_free;
   logic                                 fire;
   logic                                 sel_a, sel_b;
   logic                                 push_a, push_b;
   tcf_pkg::status_type                  status_in;
   logic signed [tcf_pkg::ID_W-1:0]      taken_in;
   tcf_pkg::q_ctrl_type                  ctrl_a, ctrl_b;
   tcf_pkg::q_stat_type                  stat_a, stat_b;

   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign fire         = in_valid_ff && out_free;
   assign req_ch.ready = !in_valid_ff || out_free;
   assign req_take     = req_ch.valid && req_ch.ready;

   always_comb begin
      sel_a     = 1'b0;
      sel_b     = 1'b0;
      push_a    = 1'b0;
      push_b    = 1'b0;
      status_in = tcf_pkg::ST_IGNORED;
      if (tcf_pkg::command_type'(cmd_ff) == tcf_pkg::CMD_ADMIT) begin
         if (id_ff != '0) begin
            if (id_ff[tcf_pkg::ID_W-1]) begin
               push_b    = !stat_b.full;
               status_in = stat_b.full ? tcf_pkg::ST_DROPPED : tcf_pkg::ST_ADMITTED;
            end else begin
               push_a    = !stat_a.full;
               status_in = stat_a.full ? tcf_pkg::ST_DROPPED : tcf_pkg::ST_ADMITTED;
            end
         end
      end else begin
         unique case (tcf_pkg::choice_type'(choice_ff))
            tcf_pkg::CH_ANY: begin
               if (!stat_a.empty && !stat_b.empty) begin
                  sel_a = tcf_pkg::stamp_older(stat_a.stamp, stat_b.stamp);
                  sel_b = !sel_a;
               end else begin
                  sel_a = !stat_a.empty;
                  sel_b = !stat_b.empty;
               end
            end
            tcf_pkg::CH_A: sel_a = !stat_a.empty;
            tcf_pkg::CH_B: sel_b = !stat_b.empty;
            default: begin
               sel_a = 1'b0;
               sel_b = 1'b0;
            end
         endcase
         if (sel_a || sel_b) begin
            status_in = tcf_pkg::ST_TAKEN;
         end
      end
      taken_in = sel_a ? stat_a.id : (sel_b ? stat_b.id : '0);
   end

   always_comb begin
      ctrl_a.push  = fire && push_a;
      ctrl_a.pop   = fire && sel_a;
      ctrl_a.id    = id_ff;
      ctrl_a.stamp = arrival_ff;
      ctrl_b.push  = fire && push_b;
      ctrl_b.pop   = fire && sel_b;
      ctrl_b.id    = id_ff;
      ctrl_b.stamp = arrival_ff;
   end

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
      arrival_in = (ctrl_a.push || ctrl_b.push) ? arrival_ff + 1'b1 : arrival_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         arrival_ff   <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         arrival_ff   <= arrival_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         cmd_ff    <= req_ch.command;
         id_ff     <= req_ch.item_id;
         choice_ff <= req_ch.choice;
      end
      if (fire) begin
         status_ff <= status_in;
         taken_ff  <= taken_in;
      end
   end

   tcf_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue_a (
      .clock (clock),
      .reset (reset),
      .ctrl  (ctrl_a),
      .stat  (stat_a)
   );

   tcf_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue_b (
      .clock (clock),
      .reset (reset),
      .ctrl  (ctrl_b),
      .stat  (stat_b)
   );

   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.status   = status_ff;
   assign rsp_ch.taken_id = taken_ff;

endmodule

// ===== sim/two_class_fifo_oldest_first_tb.sv =====
module two_class_fifo_oldest_first_tb;
   import tcf_pkg::*;

   localparam int CLASS_A      = 0;
   localparam int CLASS_B      = 1;
   localparam int RANDOM_WORDS = 1630;
   localparam int CALM_WORDS   = 150;
   localparam int LONG_HOLD    = 300;
   // choice code outside the enum, must be ignored by a take
   localparam logic [1:0] CH_UNUSED = 2'd3;

   typedef struct {
      status_type             st;
      logic signed [ID_W-1:0] tid;
   } outcome_type;

   typedef struct {
      command_type            cmd;
      logic signed [ID_W-1:0] id;
      logic [1:0]             ch;
      bit                     pinned;
      status_type             st;
      logic signed [ID_W-1:0] tid;
   } probe_row_type;

   logic clock = 1'b0;
   logic reset;

   tcf_req_if req_ch();
   tcf_rsp_if rsp_ch();

   two_class_fifo_oldest_first dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // shadow copy of both class queues
   logic signed [ID_W-1:0]  shadow_id    [2][QUEUE_DEPTH];
   logic        [STAMP_W-1:0] shadow_stamp [2][QUEUE_DEPTH];
   int                      shadow_head  [2] = '{0, 0};
   int                      shadow_tail  [2] = '{0, 0};
   int                      shadow_held  [2] = '{0, 0};
   logic        [STAMP_W-1:0] next_stamp   = '0;

   outcome_type pending_outcomes [$];
   outcome_type oldest_outcome;
   int       mismatches = 0;
   int       words_in   = 0;
   bit       calm       = 1'b0;

   probe_row_type directed_rows [0:20] = '{
      '{CMD_TAKE,  16'sh0000, CH_ANY,    1'b1, ST_IGNORED,  16'sh0000},
      '{CMD_TAKE,  16'sh0000, CH_A,      1'b1, ST_IGNORED,  16'sh0000},
      '{CMD_TAKE,  16'sh0000, CH_B,      1'b1, ST_IGNORED,  16'sh0000},
      '{CMD_TAKE,  16'sh0000, CH_UNUSED, 1'b1, ST_IGNORED,  16'sh0000},
      '{CMD_ADMIT, 16'sh0000, CH_ANY,    1'b1, ST_IGNORED,  16'sh0000},
      '{CMD_ADMIT, 16'sh7FFF, CH_ANY,    1'b1, ST_ADMITTED, 16'sh0000},
      '{CMD_ADMIT, 16'sh8000, CH_A,      1'b1, ST_ADMITTED, 16'sh0000},
      '{CMD_ADMIT, 16'sh0001, CH_B,      1'b1, ST_ADMITTED, 16'sh0000},
      '{CMD_ADMIT, 16'shFFFF, CH_UNUSED, 1'b1, ST_ADMITTED, 16'sh0000},
      '{CMD_TAKE,  16'shFFFF, CH_UNUSED, 1'b1, ST_IGNORED,  16'sh0000},
      '{CMD_TAKE,  16'sh0000, CH_ANY,    1'b1, ST_TAKEN,    16'sh7FFF},
      '{CMD_TAKE,  16'sh0000, CH_ANY,    1'b1, ST_TAKEN,    16'sh8000},
      '{CMD_TAKE,  16'sh7FFF, CH_B,      1'b1, ST_TAKEN,    16'shFFFF},
      '{CMD_TAKE,  16'sh0000, CH_A,      1'b1, ST_TAKEN,    16'sh0001},
      '{CMD_TAKE,  16'sh0000, CH_ANY,    1'b1, ST_IGNORED,  16'sh0000},
      '{CMD_ADMIT, 16'sh5555, CH_UNUSED, 1'b0, ST_IGNORED,  16'sh0000},
      '{CMD_ADMIT, 16'shAAAA, CH_ANY,    1'b0, ST_IGNORED,  16'sh0000},
      '{CMD_ADMIT, 16'sh2AAA, CH_B,      1'b0, ST_IGNORED,  16'sh0000},
      '{CMD_TAKE,  16'sh0000, CH_B,      1'b0, ST_IGNORED,  16'sh0000},
      '{CMD_TAKE,  16'sh0000, CH_ANY,    1'b0, ST_IGNORED,  16'sh0000},
      '{CMD_TAKE,  16'sh0000, CH_ANY,    1'b0, ST_IGNORED,  16'sh0000}
   };

   function automatic outcome_type shelter_outcome(input command_type cmd,
                                                   input logic signed [ID_W-1:0] id,
                                                   input logic [1:0] ch);
      outcome_type         res;
      int                  cls;
      int                  src;
      logic [STAMP_W-1:0]  age_diff;
      res.st  = ST_IGNORED;
      res.tid = '0;
      src     = -1;
      if (cmd == CMD_ADMIT) begin
         if (id != 0) begin
            cls = id[ID_W-1] ? CLASS_B : CLASS_A;
            if (shadow_held[cls] >= QUEUE_DEPTH) begin
               res.st = ST_DROPPED;
            end else begin
               shadow_id[cls][shadow_tail[cls]]    = id;
               shadow_stamp[cls][shadow_tail[cls]] = next_stamp;
               shadow_tail[cls] = (shadow_tail[cls] == QUEUE_DEPTH-1) ? 0 : shadow_tail[cls] + 1;
               shadow_held[cls]++;
               next_stamp = next_stamp + 1'b1;
               res.st = ST_ADMITTED;
            end
         end
      end else begin
         case (ch)
            CH_ANY: begin
               if (shadow_held[CLASS_A] != 0 && shadow_held[CLASS_B] != 0) begin
                  age_diff = shadow_stamp[CLASS_A][shadow_head[CLASS_A]]
                           - shadow_stamp[CLASS_B][shadow_head[CLASS_B]];
                  src = age_diff[STAMP_W-1] ? CLASS_A : CLASS_B;
               end else if (shadow_held[CLASS_A] != 0) begin
                  src = CLASS_A;
               end else if (shadow_held[CLASS_B] != 0) begin
                  src = CLASS_B;
               end
            end
            CH_A: if (shadow_held[CLASS_A] != 0) src = CLASS_A;
            CH_B: if (shadow_held[CLASS_B] != 0) src = CLASS_B;
            default: ;
         endcase
         if (src >= 0) begin
            res.tid = shadow_id[src][shadow_head[src]];
            res.st  = ST_TAKEN;
            shadow_head[src] = (shadow_head[src] == QUEUE_DEPTH-1) ? 0 : shadow_head[src] + 1;
            shadow_held[src]--;
         end
      end
      return res;
   endfunction

   function automatic logic signed [ID_W-1:0] pick_id(input int cls);
      logic [ID_W-1:0] v;
      int              r;
      r = $urandom_range(0, 19);
      v = ID_W'($urandom);
      if (r == 0) begin
         v = '0;
      end else if (r == 1) begin
         v = (cls == CLASS_B) ? 16'h8000 : 16'h7FFF;
      end else if (r == 2) begin
         v = (cls == CLASS_B) ? 16'hFFFF : 16'h0001;
      end else begin
         v[ID_W-1] = (cls == CLASS_B);
         if (cls == CLASS_A && v[ID_W-2:0] == 0) v[0] = 1'b1;
      end
      return v;
   endfunction

   // drives one word, waits for acceptance, records what must come back
   task automatic offer_word(input command_type cmd, input logic signed [ID_W-1:0] id,
                             input logic [1:0] ch, input bit pinned,
                             input status_type pin_st, input logic signed [ID_W-1:0] pin_tid);
      outcome_type res;
      req_ch.valid   <= 1'b1;
      req_ch.command <= cmd;
      req_ch.item_id <= id;
      req_ch.choice  <= ch;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      res = shelter_outcome(cmd, id, ch);
      if (pinned) begin
         res.st  = pin_st;
         res.tid = pin_tid;
      end
      pending_outcomes.push_back(res);
      words_in++;
   endtask

   task automatic source_gap();
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clock);
   endtask

   initial begin
      int          mode;
      int          flood_cls;
      int          r;
      bit          src_quiet;
      bit          admit;
      command_type cmd;
      logic signed [ID_W-1:0] id;
      logic [1:0]  ch;
      mode      = 0;
      flood_cls = CLASS_A;
      src_quiet = 1'b0;
      reset          <= 1'b1;
      req_ch.valid   <= 1'b0;
      req_ch.command <= CMD_ADMIT;
      req_ch.item_id <= '0;
      req_ch.choice  <= CH_ANY;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         offer_word(directed_rows[i].cmd, directed_rows[i].id, directed_rows[i].ch,
                    directed_rows[i].pinned, directed_rows[i].st, directed_rows[i].tid);
         if ($urandom_range(0, 3) == 0) source_gap();
      end

      for (int n = 0; n < RANDOM_WORDS; n++) begin
         // segments alternate between filling, draining, mixing and flooding one class
         if (n % 40 == 0) begin
            mode      = $urandom_range(0, 3);
            flood_cls = $urandom_range(CLASS_A, CLASS_B);
            src_quiet = ($urandom_range(0, 3) == 0);
         end
         if (n >= RANDOM_WORDS - CALM_WORDS) calm = 1'b1;
         r = $urandom_range(0, 99);
         case (mode)
            0: admit = (r < 85);
            1: admit = (r < 15);
            2: admit = (r < 50);
            default: admit = (r < 90);
         endcase
         if (admit) begin
            cmd = CMD_ADMIT;
            id  = pick_id((mode == 3) ? flood_cls : $urandom_range(CLASS_A, CLASS_B));
            ch  = 2'($urandom_range(0, 3));
         end else begin
            cmd = CMD_TAKE;
            id  = ID_W'($urandom);
            r   = $urandom_range(0, 9);
            if (r < 5)      ch = CH_ANY;
            else if (r < 7) ch = CH_A;
            else if (r < 9) ch = CH_B;
            else            ch = CH_UNUSED;
         end
         offer_word(cmd, id, ch, 1'b0, ST_IGNORED, '0);
         if (!calm && !src_quiet && $urandom_range(0, 7) == 0) source_gap();
      end

      req_ch.valid <= 1'b0;
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatches == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   // result side backpressure, including one long hold so the block fills up
   initial begin
      int hold_cycles;
      int sink_cycle;
      bit sink_quiet;
      bit long_hold_done;
      hold_cycles    = 0;
      sink_cycle     = 0;
      sink_quiet     = 1'b0;
      long_hold_done = 1'b0;
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (!long_hold_done && words_in >= 60) begin
            rsp_ch.ready <= 1'b0;
            hold_cycles = 0;
            while (hold_cycles < LONG_HOLD) begin
               @(posedge clock);
               hold_cycles++;
            end
            long_hold_done = 1'b1;
            rsp_ch.ready <= 1'b1;
         end else if (!calm && !sink_quiet && $urandom_range(0, 9) == 0) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clock);
            rsp_ch.ready <= 1'b1;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
         sink_cycle++;
         if (sink_cycle % 100 == 0) sink_quiet = ($urandom_range(0, 3) == 0);
         @(posedge clock);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_outcomes.size() == 0) begin
            $error("result word with nothing pending: status %0d taken_id %0d",
                   rsp_ch.status, rsp_ch.taken_id);
            mismatches++;
         end else begin
            oldest_outcome = pending_outcomes.pop_front();
            if (rsp_ch.status !== oldest_outcome.st) begin
               $error("status: expected %0d, actual %0d", oldest_outcome.st, rsp_ch.status);
               mismatches++;
            end
            if (rsp_ch.taken_id !== oldest_outcome.tid) begin
               $error("taken_id: expected %0d, actual %0d", oldest_outcome.tid,
                      rsp_ch.taken_id);
               mismatches++;
            end
         end
      end
   end

   initial begin
      #5000000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

// ===== two_class_fifo_oldest_first.f =====
rtl/tcf_pkg.sv
rtl/tcf_req_if.sv
rtl/tcf_rsp_if.sv
rtl/tcf_ram.sv
rtl/tcf_queue.sv
rtl/two_class_fifo_oldest_first.sv
sim/two_class_fifo_oldest_first_tb.sv
